// ===== src/swt_pkg.sv =====
// Shared types and constants of the shell word tokenizer.
package swt_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int RES_IDX_W = 3;

   localparam logic [1:0] KIND_APPEND      = 2'd0;
   localparam logic [1:0] KIND_SEGMENT_END = 2'd1;
   localparam logic [1:0] KIND_TOKEN_END   = 2'd2;

   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

   localparam logic [7:0] CHAR_BACKSLASH    = 8'h5c;
   localparam logic [7:0] CHAR_SINGLE_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_DOUBLE_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_GREATER      = 8'h3e;
   localparam logic [7:0] CHAR_LESS         = 8'h3c;
   localparam logic [7:0] CHAR_DIGIT_ONE    = 8'h31;
   localparam logic [7:0] CHAR_DIGIT_TWO    = 8'h32;
   localparam logic [7:0] CHAR_SPACE        = 8'h20;
   localparam logic [7:0] CHAR_TAB          = 8'h09;
   localparam logic [7:0] CHAR_CR           = 8'h0d;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [1:0] quote_kind;
   } result_type;

   typedef struct packed {
      logic [RES_IDX_W-1:0]        count;
      result_type [MAX_RESULTS-1:0] res;
   } bundle_type;

   typedef struct packed {
      logic [1:0] quote_mode;
      logic       escape_pending;
      logic       redirect_pending;
      logic [7:0] redirect_char;
      logic       segment_open;
      logic       lone_fd_digit;
      logic       token_has_segment;
   } lex_state_type;

endpackage

// ===== src/swt_front.sv =====
// Front end: classifies each byte, updates the lexer state and builds its result bundle.
module swt_front
   import swt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_char,
   input  logic       in_last,
   input  logic       queue_full,
   output logic       push,
   output bundle_type push_bundle
);

   typedef struct packed {
      lex_state_type st;
      bundle_type    b;
   } work_type;

   lex_state_type state_ff, state_in;
   work_type      w;
   logic          accept;

   function automatic work_type f_emit(work_type wi, logic [1:0] k, logic [7:0] ch,
                                       logic [1:0] q);
      work_type r;
      r = wi;
      if (r.b.count < RES_IDX_W'(MAX_RESULTS)) begin
         r.b.res[r.b.count].kind       = k;
         r.b.res[r.b.count].char_out   = ch;
         r.b.res[r.b.count].quote_kind = q;
         r.b.count = r.b.count + 1'b1;
      end
      return r;
   endfunction

   function automatic work_type f_append(work_type wi, logic [7:0] c);
      work_type r;
      r = wi;
      r.st.lone_fd_digit = !r.st.segment_open && (c == CHAR_DIGIT_ONE || c == CHAR_DIGIT_TWO);
      r.st.segment_open = 1'b1;
      r = f_emit(r, KIND_APPEND, c, r.st.quote_mode);
      return r;
   endfunction

   function automatic work_type f_close_segment(work_type wi);
      work_type r;
      r = wi;
      if (r.st.segment_open) begin
         r = f_emit(r, KIND_SEGMENT_END, 8'd0, r.st.quote_mode);
         r.st.segment_open = 1'b0;
         r.st.lone_fd_digit = 1'b0;
         r.st.token_has_segment = 1'b1;
      end
      return r;
   endfunction

   function automatic work_type f_close_token(work_type wi);
      work_type r;
      r = wi;
      if (r.st.token_has_segment) begin
         r = f_emit(r, KIND_TOKEN_END, 8'd0, QUOTE_NONE);
         r.st.token_has_segment = 1'b0;
      end
      return r;
   endfunction

   function automatic work_type f_handle(work_type wi, logic [7:0] c);
      work_type r;
      logic     blank;
      r = wi;
      blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
      if (r.st.escape_pending) begin
         r.st.escape_pending = 1'b0;
         r = f_append(r, c);
      end else if (c == CHAR_BACKSLASH && r.st.quote_mode != QUOTE_SINGLE) begin
         r.st.escape_pending = 1'b1;
      end else if (r.st.quote_mode == QUOTE_SINGLE) begin
         if (c == CHAR_SINGLE_QUOTE) begin
            r = f_close_segment(r);
            r.st.quote_mode = QUOTE_NONE;
         end else begin
            r = f_append(r, c);
         end
      end else if (r.st.quote_mode == QUOTE_DOUBLE) begin
         if (c == CHAR_DOUBLE_QUOTE) begin
            r = f_close_segment(r);
            r.st.quote_mode = QUOTE_NONE;
         end else begin
            r = f_append(r, c);
         end
      end else begin
         if (c == CHAR_SINGLE_QUOTE) begin
            r = f_close_segment(r);
            r.st.quote_mode = QUOTE_SINGLE;
         end else if (c == CHAR_DOUBLE_QUOTE) begin
            r = f_close_segment(r);
            r.st.quote_mode = QUOTE_DOUBLE;
         end else if (blank) begin
            r = f_close_segment(r);
            r = f_close_token(r);
         end else if (c == CHAR_GREATER || c == CHAR_LESS) begin
            if (!(c == CHAR_GREATER && r.st.lone_fd_digit)) begin
               r = f_close_segment(r);
               r = f_close_token(r);
            end
            r = f_append(r, c);
            r.st.redirect_pending = 1'b1;
            r.st.redirect_char = c;
         end else begin
            r = f_append(r, c);
         end
      end
      return r;
   endfunction

   always_comb begin
      w.st = state_ff;
      w.b = '0;
      if (w.st.redirect_pending) begin
         w.st.redirect_pending = 1'b0;
         if (in_char == w.st.redirect_char) begin
            w = f_append(w, in_char);
            w = f_close_segment(w);
            w = f_close_token(w);
         end else begin
            w = f_close_segment(w);
            w = f_close_token(w);
            w = f_handle(w, in_char);
         end
      end else begin
         w = f_handle(w, in_char);
      end
      if (in_last) begin
         w = f_close_segment(w);
         w = f_close_token(w);
         w.st = '0;
      end
   end

   assign in_ready    = !queue_full;
   assign accept      = in_valid && in_ready;
   assign push        = accept && (w.b.count != '0);
   assign push_bundle = w.b;
   assign state_in    = accept ? w.st : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   a_end_of_text_resets: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> state_ff == '0)
      else $error("lexer state not cleared after end of text");

   a_bundle_bounded: assert property (@(posedge clock) disable iff (reset)
      push |-> push_bundle.count <= RES_IDX_W'(MAX_RESULTS))
      else $error("result bundle overflows");

   a_quote_mode_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.quote_mode != 2'd3)
      else $error("quote mode corrupted");

endmodule

// ===== src/swt_queue.sv =====
// Short queue of result bundles between the front end and the back end.
module swt_queue
   import swt_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   input  logic       pop,
   output logic       full,
   output logic       empty,
   output bundle_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bundle_type       store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == FULL_CNT;
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("bundle pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count out of range");

endmodule

// ===== src/swt_back.sv =====
// Back end: sends the results of each queued bundle one beat at a time.
module swt_back
   import swt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  bundle_type head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result,
   output logic       out_last
);

   logic [RES_IDX_W-1:0] idx_ff, idx_in;
   logic                 accept;

   assign out_valid  = !empty;
   assign out_result = head.res[idx_ff];
   assign out_last   = idx_ff == head.count - 1'b1;
   assign accept     = out_valid && out_ready;
   assign pop        = accept && out_last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (accept) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_index_in_bundle: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> idx_ff < head.count)
      else $error("result index beyond bundle");

   a_index_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !out_valid |-> idx_ff == '0)
      else $error("result index not cleared while idle");

endmodule

// ===== src/shell_word_tokenizer_core.sv =====
// Top level of the shell word tokenizer: front end, bundle queue and back end.
//
//   channel   direction   payload
//   req_      in          tdata[7:0] byte of text, tlast last byte of the line
//   rsp_      out         tdata[7:0] byte, tdata[9:8] quoting, tuser kind, tlast last of byte
//
// A byte is taken in the cycle it arrives while the queue has room; its state update is
// combinational and registered in state_ff. Each byte yields zero to five result beats,
// sent at one beat per cycle while the result side is ready, so the sustained rate is one
// byte per cycle or one per result beat, whichever is slower. Synchronous reset returns
// the lexer to its start state and empties the queue. A stall on the result side fills
// the queue of QUEUE_DEPTH bundles before the input side is held.
module shell_word_tokenizer_core
   import swt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // char_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // char_out, quote_kind, zero padding
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast
);

   logic       push, pop, full, empty;
   bundle_type push_bundle, head;
   result_type out_result;

   swt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_char     (req_tdata),
      .in_last     (req_tlast),
      .queue_full  (full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   swt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (full),
      .empty       (empty),
      .head        (head)
   );

   swt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_result.quote_kind, out_result.char_out};
   assign rsp_tuser = out_result.kind;

endmodule
